/* design/dda_pkg.sv */
// shared constants and types for the dda line rasterizer
package dda_pkg;

   localparam int COORD_BITS  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int COLOR_W     = 32;
   localparam int POS_W       = COORD_BITS + FRAC_BITS;
   localparam int STEP_W      = FRAC_BITS + 2;
   localparam int CNT_W       = COORD_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(POS_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_BITS    = 4 * COORD_BITS + COLOR_W;
   localparam int RSP_BITS    = 2 * COORD_BITS + COLOR_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FRAC_BITS-1:0] HALF_FRAC = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic [STEP_W-1:0] STEP_PLUS_ONE  = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic [STEP_W-1:0] STEP_MINUS_ONE = {2'b11, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [STEP_W-1:0]     step_x;
      logic [STEP_W-1:0]     step_y;
      logic [CNT_W-1:0]      count;
      logic [COLOR_W-1:0]    color;
   } line_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* design/dda_line_rasterizer.sv */
// top level of the dda line rasterizer
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata: start_x, start_y, end_x, end_y, color
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: pixel_x, pixel_y, pixel_value
//                                              rsp_tlast: last_pixel
//
// a request is accepted in IDLE, divided one quotient bit per step in DIVIDE, queued in PUSH
// the back end emits one pixel per cycle within a line when not stalled; 1 to 64 per request
// front and back overlap through a two-deep queue, so the front divides while the back draws
// reset is synchronous and clears the control state
// rsp_tready low holds the current pixel; the front keeps working until the queue is full
module dda_line_rasterizer import dda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // start_x, start_y, end_x, end_y, pixel_color
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pixel_x, pixel_y, pixel_value
   output logic                  rsp_tlast
);

   logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
   logic [COLOR_W-1:0]    pixel_color;
   logic [COORD_BITS-1:0] pixel_x, pixel_y;
   logic [COLOR_W-1:0]    pixel_value;
   logic                  push, pop;
   line_cmd_type          push_cmd, pop_cmd;
   queue_status_type      qstat;

   assign start_x     = req_tdata[COORD_BITS-1:0];
   assign start_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign end_x       = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign end_y       = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign pixel_color = req_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS];
   assign rsp_tdata   = RSP_DATA_W'({pixel_value, pixel_y, pixel_x});

   dda_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .start_x     (start_x),
      .start_y     (start_y),
      .end_x       (end_x),
      .end_y       (end_y),
      .pixel_color (pixel_color),
      .qstat       (qstat),
      .push        (push),
      .cmd         (push_cmd)
   );

   dda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   dda_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_value (pixel_value),
      .last_pixel  (rsp_tlast)
   );

endmodule

/* design/dda_front.sv */
// front end: accepts a line request, finds the major axis and divides out the minor step
module dda_front import dda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   input  logic [COLOR_W-1:0]    pixel_color,
   input  queue_status_type      qstat,
   output logic                  push,
   output line_cmd_type          cmd
);

   typedef enum logic [1:0] {IDLE, DIVIDE, PUSH} state_type;

   state_type             state_ff, state_in;
   logic                  x_major_ff, x_major_in;
   logic                  minor_neg_ff, minor_neg_in;
   logic                  major_neg_ff, major_neg_in;
   logic [COORD_BITS-1:0] major_mag_ff, major_mag_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]      dvd_ff, dvd_in;
   logic [POS_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] sx_ff, sx_in;
   logic [COORD_BITS-1:0] sy_ff, sy_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  neg_x, neg_y, x_major;
   logic [COORD_BITS-1:0] mag_x, mag_y, minor_mag;
   logic [COORD_BITS:0]   shifted, diff;
   logic                  qbit;
   logic [STEP_W-1:0]     qmag, minor_step, unit_step;

   assign req_ready = (state_ff == IDLE);
   assign push      = (state_ff == PUSH) && !qstat.full;

   always_comb begin
      neg_x     = end_x < start_x;
      neg_y     = end_y < start_y;
      mag_x     = neg_x ? (start_x - end_x) : (end_x - start_x);
      mag_y     = neg_y ? (start_y - end_y) : (end_y - start_y);
      x_major   = mag_x >= mag_y;
      minor_mag = x_major ? mag_y : mag_x;

      shifted = {rem_ff, dvd_ff[POS_W-1]};
      diff    = shifted - {1'b0, major_mag_ff};
      qbit    = shifted >= {1'b0, major_mag_ff};

      state_in     = state_ff;
      x_major_in   = x_major_ff;
      minor_neg_in = minor_neg_ff;
      major_neg_in = major_neg_ff;
      major_mag_in = major_mag_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      color_in     = color_ff;
      count_in     = count_ff;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               x_major_in   = x_major;
               minor_neg_in = x_major ? neg_y : neg_x;
               major_neg_in = x_major ? neg_x : neg_y;
               major_mag_in = x_major ? mag_x : mag_y;
               rem_in       = '0;
               dvd_in       = {minor_mag, {FRAC_BITS{1'b0}}};
               quo_in       = '0;
               cnt_in       = '0;
               sx_in        = start_x;
               sy_in        = start_y;
               color_in     = pixel_color;
               count_in     = {1'b0, (x_major ? mag_x : mag_y)} + CNT_W'(1);
               state_in     = DIVIDE;
            end
         end
         DIVIDE: begin
            rem_in = qbit ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
            quo_in = {quo_ff[POS_W-2:0], qbit};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(POS_W - 1)) begin
               state_in = PUSH;
            end
         end
         PUSH: begin
            if (!qstat.full) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      qmag       = (major_mag_ff == '0) ? '0 : quo_ff[STEP_W-1:0];
      minor_step = minor_neg_ff ? (STEP_W'(0) - qmag) : qmag;
      unit_step  = major_neg_ff ? STEP_MINUS_ONE : STEP_PLUS_ONE;

      cmd.start_x = sx_ff;
      cmd.start_y = sy_ff;
      cmd.step_x  = x_major_ff ? unit_step : minor_step;
      cmd.step_y  = x_major_ff ? minor_step : unit_step;
      cmd.count   = count_ff;
      cmd.color   = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_major_ff   <= x_major_in;
      minor_neg_ff <= minor_neg_in;
      major_neg_ff <= major_neg_in;
      major_mag_ff <= major_mag_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      color_ff     <= color_in;
      count_ff     <= count_in;
   end

endmodule

/* design/dda_queue.sv */
// short command queue between the front and back ends
module dda_queue import dda_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  line_cmd_type     push_cmd,
   input  logic             pop,
   output line_cmd_type     pop_cmd,
   output queue_status_type qstat
);

   line_cmd_type           mem [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      qstat.full  = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      qstat.empty = (fill_ff == '0);
      pop_cmd     = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + QUEUE_IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + QUEUE_IDX_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/dda_back.sv */
// back end: steps the position accumulators; one pixel per cycle in a line unless rsp_ready stalls
module dda_back import dda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      qstat,
   input  line_cmd_type          cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] pixel_x,
   output logic [COORD_BITS-1:0] pixel_y,
   output logic [COLOR_W-1:0]    pixel_value,
   output logic                  last_pixel
);

   logic                  busy_ff, busy_in;
   logic [POS_W-1:0]      pos_x_ff, pos_x_in;
   logic [POS_W-1:0]      pos_y_ff, pos_y_in;
   logic [STEP_W-1:0]     step_x_ff, step_x_in;
   logic [STEP_W-1:0]     step_y_ff, step_y_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] px_ff, px_in;
   logic [COORD_BITS-1:0] py_ff, py_in;
   logic [COLOR_W-1:0]    pv_ff, pv_in;
   logic                  pl_ff, pl_in;
   logic                  out_free;
   logic [POS_W-1:0]      ext_x, ext_y;

   assign rsp_valid   = rsp_valid_ff;
   assign pixel_x     = px_ff;
   assign pixel_y     = py_ff;
   assign pixel_value = pv_ff;
   assign last_pixel  = pl_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      pop      = !busy_ff && !qstat.empty;
      ext_x    = {{(POS_W-STEP_W){step_x_ff[STEP_W-1]}}, step_x_ff};
      ext_y    = {{(POS_W-STEP_W){step_y_ff[STEP_W-1]}}, step_y_ff};

      busy_in      = busy_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      left_in      = left_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pv_in        = pv_ff;
      pl_in        = pl_ff;

      if (pop) begin
         busy_in   = 1'b1;
         pos_x_in  = {cmd.start_x, HALF_FRAC};
         pos_y_in  = {cmd.start_y, HALF_FRAC};
         step_x_in = cmd.step_x;
         step_y_in = cmd.step_y;
         left_in   = cmd.count;
         color_in  = cmd.color;
      end

      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            px_in        = pos_x_ff[POS_W-1:FRAC_BITS];
            py_in        = pos_y_ff[POS_W-1:FRAC_BITS];
            pv_in        = color_ff;
            pl_in        = (left_ff == CNT_W'(1));
            pos_x_in     = pos_x_ff + ext_x;
            pos_y_in     = pos_y_ff + ext_y;
            left_in      = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      left_ff   <= left_in;
      color_ff  <= color_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pv_ff     <= pv_in;
      pl_ff     <= pl_in;
   end

endmodule

/* design/dda_checker.sv */
// port-level assertions for the dda line rasterizer, bound to the top level
module dda_checker import dda_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic                  in_line_ff, in_line_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic [COORD_BITS-1:0] cur_x, cur_y;
   logic                  rsp_fire, near_x, near_y;

   always_comb begin
      rsp_fire   = rsp_tvalid && rsp_tready;
      cur_x      = rsp_tdata[COORD_BITS-1:0];
      cur_y      = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
      near_x     = (cur_x == prev_x_ff) || (cur_x == prev_x_ff + COORD_BITS'(1))
                   || (prev_x_ff == cur_x + COORD_BITS'(1));
      near_y     = (cur_y == prev_y_ff) || (cur_y == prev_y_ff + COORD_BITS'(1))
                   || (prev_y_ff == cur_y + COORD_BITS'(1));
      in_line_in = in_line_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (rsp_fire) begin
         in_line_in = !rsp_tlast;
         prev_x_in  = cur_x;
         prev_y_in  = cur_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff <= 1'b0;
      end else begin
         in_line_ff <= in_line_in;
      end
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
   end

   // no pixel right after reset
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // the front end is busy dividing after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   // stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled pixel changed");

   // pixels within a line are neighbors
   a_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && in_line_ff) |-> (near_x && near_y))
      else $error("consecutive pixels of a line are not adjacent");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* tb/sv/dda_line_rasterizer_tb.sv */
// self-checking testbench for the dda line rasterizer: directed and random line requests
module dda_line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dda_pkg::*;

   localparam int RANDOM_LINES = 110;
   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
      logic [COLOR_W-1:0]    color;
   } segment_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_W-1:0]    value;
      logic                  last;
   } pixel_type;

   typedef struct {
      segment_type seg;
      bit          typed;
      pixel_type   point;
   } row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // start_x, start_y, end_x, end_y, pixel_color
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // pixel_x, pixel_y, pixel_value
   logic                  rsp_tlast;

   row_type   line_rows[$];
   pixel_type pending_pixels[$];
   int        errors      = 0;
   int        lines_sent  = 0;
   int        pixels_seen = 0;
   int        idle_cycles = 0;
   int        stall_mode  = 0;
   int        stall_left  = 0;

   dda_line_rasterizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report(string field, longint unsigned want, longint unsigned got);
      $display("mismatch on %s at pixel %0d: expected %0h, got %0h",
               field, pixels_seen, want, got);
      errors++;
   endtask

   function automatic logic [STEP_W-1:0] minor_slope(logic neg, logic [COORD_BITS-1:0] minor,
                                                     logic [COORD_BITS-1:0] major);
      logic [POS_W-1:0] quot;
      if (major == '0) return '0;
      quot = {minor, {FRAC_BITS{1'b0}}} / POS_W'(major);
      return neg ? STEP_W'(-quot) : STEP_W'(quot);
   endfunction

   task automatic trace_line(segment_type seg);
      logic                  neg_x;
      logic                  neg_y;
      logic [COORD_BITS-1:0] mag_x;
      logic [COORD_BITS-1:0] mag_y;
      logic [STEP_W-1:0]     step_x;
      logic [STEP_W-1:0]     step_y;
      logic [POS_W-1:0]      pos_x;
      logic [POS_W-1:0]      pos_y;
      pixel_type             px;
      int                    count;
      neg_x = seg.x1 < seg.x0;
      neg_y = seg.y1 < seg.y0;
      mag_x = neg_x ? seg.x0 - seg.x1 : seg.x1 - seg.x0;
      mag_y = neg_y ? seg.y0 - seg.y1 : seg.y1 - seg.y0;
      if (mag_x >= mag_y) begin
         step_x = neg_x ? STEP_MINUS_ONE : STEP_PLUS_ONE;
         step_y = minor_slope(neg_y, mag_y, mag_x);
         count  = int'(mag_x) + 1;
      end else begin
         step_x = minor_slope(neg_x, mag_x, mag_y);
         step_y = neg_y ? STEP_MINUS_ONE : STEP_PLUS_ONE;
         count  = int'(mag_y) + 1;
      end
      pos_x = {seg.x0, HALF_FRAC};
      pos_y = {seg.y0, HALF_FRAC};
      for (int i = 0; i < count; i++) begin
         px.x     = pos_x[POS_W-1 -: COORD_BITS];
         px.y     = pos_y[POS_W-1 -: COORD_BITS];
         px.value = seg.color;
         px.last  = (i == count - 1);
         pending_pixels.push_back(px);
         pos_x = pos_x + {{(POS_W-STEP_W){step_x[STEP_W-1]}}, step_x};
         pos_y = pos_y + {{(POS_W-STEP_W){step_y[STEP_W-1]}}, step_y};
      end
   endtask

   // typed rows are single points whose one pixel is given directly
   task automatic table_row(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] color,
                            bit typed = 1'b0, int px = 0, int py = 0);
      row_type row;
      row.seg.x0      = COORD_BITS'(x0);
      row.seg.y0      = COORD_BITS'(y0);
      row.seg.x1      = COORD_BITS'(x1);
      row.seg.y1      = COORD_BITS'(y1);
      row.seg.color   = color;
      row.typed       = typed;
      row.point.x     = COORD_BITS'(px);
      row.point.y     = COORD_BITS'(py);
      row.point.value = color;
      row.point.last  = 1'b1;
      line_rows.push_back(row);
   endtask

   function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
      return COORD_BITS'(v);
   endfunction

   initial begin
      row_type     row;
      segment_type seg;
      int          kind;
      int          burst;
      int          idx;

      table_row( 0,  0,  0,  0, 32'h0000_0000, 1'b1,  0,  0);
      table_row(63, 63, 63, 63, 32'hffff_ffff, 1'b1, 63, 63);
      table_row(21, 42, 21, 42, 32'ha5a5_a5a5, 1'b1, 21, 42);
      table_row( 0,  0, 63,  0, 32'h5555_5555);
      table_row(63, 63,  0, 63, 32'haaaa_aaaa);
      table_row( 0,  0,  0, 63, 32'h8000_0001);
      table_row( 5, 63,  5,  0, 32'h7fff_fffe);
      table_row( 0,  0, 63, 63, 32'h1234_5678);
      table_row(63,  0,  0, 63, 32'h9abc_def0);
      table_row(10, 10, 13, 13, 32'hff00_ff00);
      table_row( 3,  0, 10, 63, 32'h00ff_00ff);
      table_row(60, 63,  2,  0, 32'hdead_beef);
      table_row( 0,  5, 63, 40, 32'h0f0f_0f0f);
      table_row(63, 40,  0,  5, 32'hf0f0_f0f0);
      table_row( 7,  7,  8,  8, 32'h0000_0001);
      table_row( 7,  7,  7,  8, 32'h8000_0000);
      table_row( 0,  0,  1,  2, 32'h3c3c_3c3c);
      table_row(63,  0, 62, 63, 32'hc3c3_c3c3);
      table_row( 0,  0, 62, 63, 32'h1111_1111);
      table_row( 0,  0, 63, 62, 32'heeee_eeee);
      table_row(40, 20, 20, 40, 32'h2468_ace0);

      for (int n = 0; n < RANDOM_LINES; n++) begin
         seg.x0    = COORD_BITS'($urandom);
         seg.y0    = COORD_BITS'($urandom);
         seg.x1    = COORD_BITS'($urandom);
         seg.y1    = COORD_BITS'($urandom);
         seg.color = $urandom;
         kind      = $urandom_range(0, 9);
         if (kind >= 6 && kind <= 8) begin
            seg.x1 = nudge(seg.x0);
            seg.y1 = nudge(seg.y0);
         end else if (kind == 9) begin
            if ($urandom_range(0, 1) == 1) seg.x1 = seg.x0;
            else seg.y1 = seg.y0;
         end
         row.seg   = seg;
         row.typed = 1'b0;
         row.point = '0;
         line_rows.push_back(row);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < line_rows.size()) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && idx < line_rows.size()) begin
            row = line_rows[idx];
            req_tvalid <= 1'b1;
            req_tdata  <= {row.seg.color, row.seg.y1, row.seg.x1, row.seg.y0, row.seg.x0};
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            if (row.typed) pending_pixels.push_back(row.point);
            else trace_line(row.seg);
            lines_sent++;
            idx++;
            burst--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d line requests in all octants, single points and full-span lines", lines_sent);
      $display("%0d pixels checked under random bursts and stalls, %0d mismatches",
               pixels_seen, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver: all-ready, coin-flip, mostly-ready and fixed-pattern stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
               rsp_tready <= 1'(16'b1011_0001_1100_1110 >> (stall_left % 16));
            end
         endcase
      end
   end

   always @(posedge clock) begin : watch_pixels
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report("unexpected pixel", 64'(0), 64'(rsp_tdata));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[COORD_BITS-1:0] != want.x)
               report("pixel_x", 64'(want.x), 64'(rsp_tdata[COORD_BITS-1:0]));
            if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] != want.y)
               report("pixel_y", 64'(want.y), 64'(rsp_tdata[2*COORD_BITS-1:COORD_BITS]));
            if (rsp_tdata[RSP_BITS-1:2*COORD_BITS] != want.value)
               report("pixel_value", 64'(want.value), 64'(rsp_tdata[RSP_BITS-1:2*COORD_BITS]));
            if (rsp_tdata[RSP_DATA_W-1:RSP_BITS] != '0)
               report("tdata padding", 64'(0), 64'(rsp_tdata[RSP_DATA_W-1:RSP_BITS]));
            if (rsp_tlast !== want.last)
               report("last_pixel", 64'(want.last), 64'(rsp_tlast));
         end
         pixels_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or pixel moved for %0d cycles, %0d pixels pending",
                  idle_cycles, pending_pixels.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* dda_line_rasterizer.f */
design/dda_pkg.sv
design/dda_front.sv
design/dda_queue.sv
design/dda_back.sv
design/dda_line_rasterizer.sv
design/dda_checker.sv
tb/sv/dda_line_rasterizer_tb.sv
